>>> hw/rtl/escape_time_fractal_pixel_assert.svh
// assertion macros for the escape-time fractal pixel block
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ETFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define ETFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/etfp_pkg.sv
// types, constants and helper functions of the escape-time fractal pixel block
`timescale 1ns / 1ps

package etfp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STEP      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_REAL     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_IMAG     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 2'd3;

	// register reset values
	localparam logic [30:0]        PIXEL_STEP_RST      = 31'd1073741;
	localparam logic signed [31:0] CENTER_REAL_RST     = -32'sd134217728;
	localparam logic signed [31:0] CENTER_IMAG_RST     = 32'sd0;
	localparam logic [15:0]        ITERATION_LIMIT_RST = 16'd1000;

	// |z|^2 > 4 at Q8.56
	localparam logic [63:0] BAILOUT_Q56 = 64'h0400_0000_0000_0000;

	localparam int unsigned Q_FRAC = 28;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MAP_X  = 9'b000000010,
		ST_MAP_Y  = 9'b000000100,
		ST_SEED   = 9'b000001000,
		ST_SQ_RE  = 9'b000010000,
		ST_SQ_IM  = 9'b000100000,
		ST_CROSS  = 9'b001000000,
		ST_UPDATE = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// clamp a wide signed value to the q4.28 range
	function automatic logic signed [31:0] sat_q428(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v[63:31] == '0 || v[63:31] == '1) begin
			r = v[31:0];
		end else if (v[63]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	// escape count to colour, all components wrap modulo 256
	function automatic rgb_t colour_of(input logic [15:0] n, input logic [15:0] limit);
		rgb_t       c;
		logic [7:0] u;
		u = n[7:0];
		c = '0;
		if (n == limit) begin
			c = '0;
		end else if (n == 16'd0) begin
			c.red = 8'd255;
		end else if (n < 16'd16) begin
			c.red  = 8'((8'd16 - u) << 4);
			c.blue = 8'((u << 4) - 8'd1);
		end else if (u < 8'd32) begin
			c.green = 8'((u - 8'd16) << 4);
			c.blue  = 8'(((8'd32 - u) << 4) - 8'd1);
		end else if (u < 8'd64) begin
			c.red   = 8'((u - 8'd32) << 3);
			c.green = 8'(((8'd64 - u) << 3) - 8'd1);
		end else begin
			c.red = 8'(8'd255 - ((u - 8'd64) << 2));
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/escape_time_fractal_pixel.sv
// top level of the escape-time fractal pixel block
`timescale 1ns / 1ps

// escape-time fractal pixel: an item is one pixel (pixel_x, pixel_y). it is
// mapped to c = (2*p - size) * pixel_step / 2 + center, saturated to signed
// q4.28, and z = z^2 + c is iterated from z = c until |z|^2 > 4 or the count
// reaches iteration_limit. the result item carries the count, an in-set flag
// and an rgb colour (black inside the set). all products go through one
// registered 32x32 signed multiplier: mapping takes two products, and every
// iteration takes three (re^2, im^2, re*im). one item is worked on at a
// time; in_ready is high only between items. the finished result sits in
// an output register, so the next pixel is taken while the previous result
// still waits for out_ready. configuration writes take effect at once and
// must only be issued while the block is idle.
module escape_time_fractal_pixel
	import etfp_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 768
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	// pixel items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [9:0]             pixel_x,
	input  logic [9:0]             pixel_y,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            escape_count,
	output logic                   inside_set,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);

`include "escape_time_fractal_pixel_assert.svh"

	// configuration registers
	logic [30:0]        pixel_step_q;
	logic signed [31:0] center_real_q;
	logic signed [31:0] center_imag_q;
	logic [15:0]        iteration_limit_q;

	// sequencer and working registers
	state_t             state_q, state_d;
	logic [9:0]         px_q, py_q;
	logic [15:0]        limit_q;
	logic [15:0]        n_q;
	logic signed [31:0] c_re_q, c_im_q;
	logic signed [31:0] z_re_q, z_im_q;
	logic [63:0]        re2_q;
	logic signed [63:0] diff_q;

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] prod_q;

	// output register
	logic               out_valid_q;
	logic [15:0]        count_q;
	logic               inside_q;
	rgb_t               rgb_q;

	// derived values
	logic signed [31:0] twice_x, twice_y;
	logic signed [31:0] step_s;
	logic signed [31:0] map_c;
	logic [63:0]        sq_sum;
	logic               bail;
	logic               at_limit;
	logic               out_free;
	logic               in_fire;
	rgb_t               rgb_d;

	// (2*p - size), exact in 32 bits for every legal image size
	assign twice_x = $signed({21'd0, px_q, 1'b0}) - 32'(IMAGE_WIDTH);
	assign twice_y = $signed({21'd0, py_q, 1'b0}) - 32'(IMAGE_HEIGHT);
	assign step_s  = $signed({1'b0, pixel_step_q});

	// product halved toward minus infinity, offset added, saturated;
	// in ST_MAP_Y the product is the x axis, in ST_SEED the y axis
	always_comb begin
		if (state_q == ST_MAP_Y) begin
			map_c = sat_q428((prod_q >>> 1) + 64'(center_real_q));
		end else begin
			map_c = sat_q428((prod_q >>> 1) + 64'(center_imag_q));
		end
	end

	// bailout test at full q8.56 width; both squares are non-negative
	assign sq_sum   = re2_q + 64'(prod_q);
	assign bail     = sq_sum > BAILOUT_Q56;
	assign at_limit = n_q == limit_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign rgb_d    = colour_of(n_q, limit_q);

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MAP_X: begin
				mul_a = twice_x;
				mul_b = step_s;
			end
			ST_MAP_Y: begin
				mul_a = twice_y;
				mul_b = step_s;
			end
			ST_SQ_RE: begin
				mul_a = z_re_q;
				mul_b = z_re_q;
			end
			ST_SQ_IM: begin
				mul_a = z_im_q;
				mul_b = z_im_q;
			end
			ST_CROSS: begin
				mul_a = z_re_q;
				mul_b = z_im_q;
			end
			default: begin
				mul_a = z_re_q;
				mul_b = z_im_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MAP_X;
			ST_MAP_X:  state_d = ST_MAP_Y;
			ST_MAP_Y:  state_d = ST_SEED;
			ST_SEED:   state_d = ST_SQ_RE;
			// count checked before each step, so a zero limit takes no step
			ST_SQ_RE:  state_d = at_limit ? ST_DONE : ST_SQ_IM;
			ST_SQ_IM:  state_d = ST_CROSS;
			ST_CROSS:  state_d = bail ? ST_DONE : ST_UPDATE;
			ST_UPDATE: state_d = ST_SQ_RE;
			// wait here only while the previous result is still held
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_step_q      <= PIXEL_STEP_RST;
			center_real_q     <= CENTER_REAL_RST;
			center_imag_q     <= CENTER_IMAG_RST;
			iteration_limit_q <= ITERATION_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_STEP:      pixel_step_q      <= cfg_data[30:0];
				REG_CENTER_REAL:     center_real_q     <= $signed(cfg_data);
				REG_CENTER_IMAG:     center_imag_q     <= $signed(cfg_data);
				REG_ITERATION_LIMIT: iteration_limit_q <= cfg_data[15:0];
				default:             pixel_step_q      <= pixel_step_q;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_fire) begin
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			limit_q <= iteration_limit_q;
		end
		if (state_q == ST_MAP_Y) begin
			c_re_q <= map_c;
		end
		if (state_q == ST_SEED) begin
			c_im_q <= map_c;
			z_re_q <= c_re_q;
			z_im_q <= map_c;
		end
		if (state_q == ST_SQ_IM) begin
			re2_q <= 64'(prod_q);
		end
		if (state_q == ST_CROSS) begin
			diff_q <= $signed(re2_q) - prod_q;
		end
		// new z from the old z: cross term and difference of squares
		if (state_q == ST_UPDATE) begin
			z_im_q <= sat_q428((prod_q >>> (Q_FRAC - 1)) + 64'(c_im_q));
			z_re_q <= sat_q428((diff_q >>> Q_FRAC) + 64'(c_re_q));
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (in_fire) begin
			n_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			n_q <= n_q + 16'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			count_q  <= n_q;
			inside_q <= at_limit;
			rgb_q    <= rgb_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = count_q;
	assign inside_set   = inside_q;
	assign red          = rgb_q.red;
	assign green        = rgb_q.green;
	assign blue         = rgb_q.blue;

	// the count never runs past the limit captured with the pixel
	`ETFP_ASSERT_NOW(a_count_bounded, state_q != ST_IDLE, n_q <= limit_q,
		"step count passed the iteration limit")

	// a point inside the set is always drawn black
	`ETFP_ASSERT_NOW(a_inside_black, out_valid && inside_set,
		red == 8'd0 && green == 8'd0 && blue == 8'd0, "inside point not black")

	// a result only appears after the sequencer finished an item
	`ETFP_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state_q) == ST_DONE,
		"result shown without a finished item")

endmodule

>>> tb/testbench.sv
// testbench for the escape-time fractal pixel block
`timescale 1ns / 1ps

// the testbench drives pixel items through the valid/ready input, keeps its
// own fixed-point model of the mapping, the z = z^2 + c iteration and the
// colour gradient, and checks every result item against the oldest pending
// prediction. the view (step, centre, iteration limit) is only changed while
// the block is idle, after every pending result has come back.
module testbench
	import etfp_pkg::*;
();

	localparam int IMG_W = 1024;
	localparam int IMG_H = 768;

	// about 600 random pixels after the directed part
	localparam int unsigned RANDOM_ITEMS = 600;
	// cycles to watch for stray results once everything is back
	localparam int unsigned TAIL_CYCLES = 40;

	// one in q4.28
	localparam int ONE_Q = 268435456;

	// |z|^2 > 4 at q8.56
	localparam logic [63:0] RADIUS2_Q56 = 64'h0400_0000_0000_0000;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [15:0] count;
		logic        in_set;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pixel_result_t;

	typedef struct {
		logic [9:0]    px;
		logic [9:0]    py;
		pixel_result_t res;
	} pending_pixel_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [9:0]             pixel_x;
	logic [9:0]             pixel_y;
	logic                   out_valid;
	logic                   out_ready;
	logic [15:0]            escape_count;
	logic                   inside_set;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;

	// copy of the view registers as the block should hold them
	logic [30:0]        step_q;
	logic signed [31:0] ctr_re;
	logic signed [31:0] ctr_im;
	logic [15:0]        iter_max;

	pending_pixel_t pending_pixels[$];
	int unsigned    mismatches;
	// when set, neither side inserts gaps
	bit             steady;

	escape_time_fractal_pixel #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.escape_count(escape_count),
		.inside_set  (inside_set),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// fixed-point model of one pixel
	// ------------------------------------------------------------------

	// clamp to the signed q4.28 range, about +-8
	function automatic logic signed [31:0] clamp_q428(input longint v);
		if (v > Q_MAX) begin
			return 32'sh7fff_ffff;
		end
		if (v < Q_MIN) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// (2*pix - size) * step is exact, the halving rounds toward minus infinity
	function automatic logic signed [31:0] map_coord(input logic [9:0] pix, input int size,
			input logic signed [31:0] offset);
		longint twice;
		longint prod;
		longint off_wide;
		twice = longint'(pix) * 2 - size;
		prod = twice * longint'(step_q);
		off_wide = offset;
		return clamp_q428((prod >>> 1) + off_wide);
	endfunction

	// gradient red -> blue -> green -> red on the low byte, wrapping mod 256
	function automatic logic [23:0] pixel_colour(input int unsigned n, input int unsigned lim);
		int nn;
		int u;
		int r;
		int g;
		int b;
		nn = n;
		u = nn & 255;
		r = 0;
		g = 0;
		b = 0;
		if (n == lim) begin
			r = 0;
		end else if (nn == 0) begin
			r = 255;
		end else if (nn < 16) begin
			r = 16 * (16 - nn);
			b = 16 * nn - 1;
		end else if (u < 32) begin
			g = 16 * (u - 16);
			b = 16 * (32 - u) - 1;
		end else if (u < 64) begin
			r = 8 * (u - 32);
			g = 8 * (64 - u) - 1;
		end else begin
			r = 255 - 4 * (u - 64);
		end
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [9:0] px, input logic [9:0] py);
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic signed [31:0] z_re;
		logic signed [31:0] z_im;
		longint             re_w;
		longint             im_w;
		longint             re2;
		longint             im2;
		longint             re_im;
		logic [63:0]        mag;
		int unsigned        n;
		bit                 escaped;
		pixel_result_t      res;
		c_re = map_coord(px, IMG_W, ctr_re);
		c_im = map_coord(py, IMG_H, ctr_im);
		z_re = c_re;
		z_im = c_im;
		n = 0;
		escaped = 1'b0;
		while (!escaped && n < iter_max) begin
			re_w = z_re;
			im_w = z_im;
			re2 = re_w * re_w;
			im2 = im_w * im_w;
			re_im = re_w * im_w;
			// bailout is exact at full width, before any rescale
			mag = re2 + im2;
			if (mag > RADIUS2_Q56) begin
				escaped = 1'b1;
			end else begin
				// 2*re*im is a shift by one less
				z_im = clamp_q428((re_im >>> 27) + longint'(c_im));
				z_re = clamp_q428(((re2 - im2) >>> 28) + longint'(c_re));
				n++;
			end
		end
		res.count = n[15:0];
		res.in_set = (n == iter_max);
		{res.red, res.green, res.blue} = pixel_colour(n, iter_max);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// gap length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// writes all four view registers back to back; block must be idle
	task automatic load_view(input logic [31:0] step_word, input logic [31:0] re_word,
			input logic [31:0] im_word, input logic [31:0] limit_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_PIXEL_STEP;
		cfg_data <= step_word;
		@(posedge clk);
		cfg_index <= REG_CENTER_REAL;
		cfg_data <= re_word;
		@(posedge clk);
		cfg_index <= REG_CENTER_IMAG;
		cfg_data <= im_word;
		@(posedge clk);
		cfg_index <= REG_ITERATION_LIMIT;
		cfg_data <= limit_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		// step is 31 bits and the limit 16, upper data bits are dropped
		step_q = step_word[30:0];
		ctr_re = re_word;
		ctr_im = im_word;
		iter_max = limit_word[15:0];
	endtask

	// sends one pixel item; valid stays high on return so a back-to-back item
	// needs no second assignment in the same step
	task automatic offer_pixel(input logic [9:0] px, input logic [9:0] py);
		int unsigned    gap;
		pending_pixel_t entry;
		gap = steady ? 0 : idle_len();
		entry.px = px;
		entry.py = py;
		entry.res = predict_pixel(px, py);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (!in_ready);
		pending_pixels = {pending_pixels, entry};
	endtask

	// stop sending and wait until every predicted result has come back
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// no writes: the reset view, centre point is inside at the limit of 1000
	task automatic test_reset_config();
		offer_pixel(10'd512, 10'd384);
		offer_pixel(10'd0, 10'd0);
		offer_pixel(10'd1023, 10'd767);
		drain_pixels();
	endtask

	// saturation of the plane mapping, zero step, pixels past the image
	task automatic test_plane_extremes();
		// largest step, bit 31 of the data must be dropped; edges saturate at +-8
		load_view(32'hffff_ffff, 32'd0, 32'd0, 32'd40);
		offer_pixel(10'd0, 10'd0);
		offer_pixel(10'd1023, 10'd1023);
		offer_pixel(10'd512, 10'd384);
		offer_pixel(10'd511, 10'd383);
		offer_pixel(10'd513, 10'd385);
		drain_pixels();
		// smallest step, centre at the most negative real and most positive imag
		load_view(32'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0010);
		offer_pixel(10'd0, 10'd0);
		offer_pixel(10'd1023, 10'd1023);
		drain_pixels();
		// zero step: every pixel lands on the centre, here just outside the set
		load_view(32'd0, 32'(ONE_Q / 10 * 3), 32'd0, 32'd300);
		offer_pixel(10'd0, 10'd0);
		offer_pixel(10'd1023, 10'd767);
		offer_pixel(10'd777, 10'd123);
		drain_pixels();
	endtask

	// iteration limits of 0, 1 and the maximum
	task automatic test_limit_extremes();
		// zero limit: no step, count 0, flagged inside, black
		load_view(32'd0, 32'd0, 32'd0, 32'd0);
		offer_pixel(10'd5, 10'd5);
		offer_pixel(10'd1000, 10'd700);
		drain_pixels();
		// limit of one: origin is inside after one step, the corner saturates
		load_view(32'h7fff_ffff, 32'd0, 32'd0, 32'd1);
		offer_pixel(10'd512, 10'd384);
		offer_pixel(10'd0, 10'd0);
		drain_pixels();
		// full 16-bit limit: one long item at the origin, one quick escape
		load_view(32'h7fff_ffff, 32'd0, 32'd0, 32'hffff);
		offer_pixel(10'd512, 10'd384);
		offer_pixel(10'd0, 10'd767);
		drain_pixels();
	endtask

	// random views, mostly zoomed near the set boundary, with small limits so
	// the run stays short; a few views use large limits with fewer pixels
	task automatic test_random_views();
		int unsigned sent;
		int unsigned batch;
		int unsigned pick;
		int unsigned lim;
		int          base_re;
		int          base_im;
		logic [31:0] step_word;
		logic [31:0] re_word;
		logic [31:0] im_word;
		logic [9:0]  px;
		logic [9:0]  py;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				step_word = 32'd0;
			end else if (pick < 50) begin
				step_word = $urandom_range(1, 4000000);
			end else if (pick < 80) begin
				step_word = $urandom_range(1, 200000);
			end else if (pick < 95) begin
				step_word = $urandom_range(1, 30000000);
			end else begin
				step_word = $urandom;
			end
			step_word[31] = 1'($urandom_range(0, 1));

			// boundary points of interest, with a little jitter
			case ($urandom_range(0, 5))
				0: begin
					base_re = -(ONE_Q / 4 * 3);
					base_im = ONE_Q / 10;
				end
				1: begin
					base_re = -(ONE_Q / 4 * 5);
					base_im = ONE_Q / 50;
				end
				2: begin
					base_re = ONE_Q / 100 * 28;
					base_im = ONE_Q / 125;
				end
				3: begin
					base_re = -(ONE_Q / 2);
					base_im = 0;
				end
				4: begin
					base_re = -(ONE_Q / 10);
					base_im = ONE_Q / 100 * 65;
				end
				default: begin
					base_re = $urandom;
					base_im = $urandom;
				end
			endcase
			re_word = base_re + int'($urandom_range(0, 4194304)) - 2097152;
			im_word = base_im + int'($urandom_range(0, 4194304)) - 2097152;

			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				lim = $urandom_range(1, 64);
			end else if (pick < 95) begin
				lim = $urandom_range(65, 400);
			end else begin
				lim = $urandom_range(401, 1000);
			end

			// some views run with no gaps on either side
			steady = ($urandom_range(0, 4) == 0);
			load_view(step_word, re_word, im_word, {16'($urandom), lim[15:0]});

			batch = (lim > 400) ? 10 : $urandom_range(30, 50);
			repeat (batch) begin
				px = 10'($urandom_range(0, 1023));
				// now and then a row below the image
				py = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(768, 1023))
					: 10'($urandom_range(0, 767));
				offer_pixel(px, py);
			end
			sent += batch;
			drain_pixels();
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// output stalls of random length, with runs of steady ready
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : idle_len();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// every accepted result item against the oldest prediction
	always @(posedge clk) begin : check_results
		pending_pixel_t want;
		pixel_result_t  seen;
		if (arst_n && out_valid && out_ready) begin
			seen = {escape_count, inside_set, red, green, blue};
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result item: count %0d inside %0d rgb %0d,%0d,%0d",
						seen.count, seen.in_set, seen.red, seen.green, seen.blue);
				end
			end else begin
				want = pending_pixels.pop_front();
				if (seen.count !== want.res.count || seen.in_set !== want.res.in_set ||
						seen.red !== want.res.red || seen.green !== want.res.green ||
						seen.blue !== want.res.blue) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("pixel (%0d,%0d): expected count %0d inside %0d rgb %0d,%0d,%0d",
							want.px, want.py, want.res.count, want.res.in_set,
							want.res.red, want.res.green, want.res.blue);
						$display("  got count %0d inside %0d rgb %0d,%0d,%0d",
							seen.count, seen.in_set, seen.red, seen.green, seen.blue);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PIXEL_STEP;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		out_ready = 1'b0;
		mismatches = 0;
		steady = 1'b0;
		// view registers as they come out of reset
		step_q = PIXEL_STEP_RST;
		ctr_re = CENTER_REAL_RST;
		ctr_im = CENTER_IMAG_RST;
		iter_max = ITERATION_LIMIT_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_plane_extremes();
		test_limit_extremes();
		test_random_views();

		// watch a little longer for stray result items
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#300_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
